// ===== src/ssle_pkg.sv =====
// ----------------------------------------------------------------------------
// ssle_pkg
// shared constants, types and helper functions of the sparse slot list engine
// ----------------------------------------------------------------------------
package ssle_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int ADDR_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam int OP_W       = 4;
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 8;
  localparam int STS_W      = 2;
  localparam int CNT_OUT_W  = 7;

  // widths used to compare or resize without losing bits
  localparam int CMP_W      = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
  localparam int CNT_CMP_W  = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam int CNT_SAT    = (2 ** CNT_OUT_W) - 1;

  localparam logic [ADDR_W-1:0] MID_SLOT  = ADDR_W'(SLOT_COUNT / 2);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(SLOT_COUNT - 1);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR     = 4'd0,
    OP_INS_FIRST = 4'd1,
    OP_INS_LAST  = 4'd2,
    OP_WRITE     = 4'd3,
    OP_DEL_FIRST = 4'd4,
    OP_DEL_LAST  = 4'd5,
    OP_DEL_AT    = 4'd6,
    OP_READ      = 4'd7,
    OP_QUERY     = 4'd8
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK      = 2'd0,
    STS_EMPTY   = 2'd1,
    STS_NO_ROOM = 2'd2
  } sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_APPLY,
    S_REPORT,
    S_SCAN,
    S_SCAN_END
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic apply;
    logic report;
    logic scan_start;
    logic scan_step;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_stat_t;

  // lowest set bit of the occupancy vector, zero when none
  function automatic logic [ADDR_W-1:0] find_first(input logic [SLOT_COUNT-1:0] occ);
    logic [ADDR_W-1:0] pos;
    pos = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (occ[i]) pos = ADDR_W'(i);
    end
    return pos;
  endfunction

  // highest set bit of the occupancy vector, zero when none
  function automatic logic [ADDR_W-1:0] find_last(input logic [SLOT_COUNT-1:0] occ);
    logic [ADDR_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (occ[i]) pos = ADDR_W'(i);
    end
    return pos;
  endfunction

endpackage

// ===== src/ssle_ram.sv =====
// ----------------------------------------------------------------------------
// ssle_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ssle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ssle_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssle_ctrl
// sequencer: one operation in fetch, apply, report steps; occupancy rebuild
// sweep after every empty marker write
// ----------------------------------------------------------------------------
module ssle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               cfg_wr,
  input  ssle_pkg::dp_stat_t stat,
  output logic               busy,
  output ssle_pkg::dp_cmd_t  cmd
);

  ssle_pkg::ctl_state_t state_r, state_nxt;
  logic                 pend_r, pend_nxt;
  logic                 accept;

  assign busy   = (state_r != ssle_pkg::S_IDLE) | pend_r | cfg_wr;
  assign accept = start & ~busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssle_pkg::S_IDLE: begin
        priority if (pend_r) state_nxt = ssle_pkg::S_SCAN;
        else if (accept)     state_nxt = ssle_pkg::S_FETCH;
      end
      ssle_pkg::S_FETCH:    state_nxt = ssle_pkg::S_APPLY;
      ssle_pkg::S_APPLY:    state_nxt = ssle_pkg::S_REPORT;
      ssle_pkg::S_REPORT:   state_nxt = ssle_pkg::S_IDLE;
      ssle_pkg::S_SCAN: begin
        if (stat.scan_last) state_nxt = ssle_pkg::S_SCAN_END;
      end
      ssle_pkg::S_SCAN_END: state_nxt = ssle_pkg::S_IDLE;
      default:              state_nxt = ssle_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd            = '0;
    cmd.load       = accept;
    cmd.scan_start = (state_r == ssle_pkg::S_IDLE) & pend_r;
    cmd.fetch      = (state_r == ssle_pkg::S_FETCH);
    cmd.apply      = (state_r == ssle_pkg::S_APPLY);
    cmd.report     = (state_r == ssle_pkg::S_REPORT);
    cmd.scan_step  = (state_r == ssle_pkg::S_SCAN);
  end

  // a marker write during a sweep asks for another full sweep
  always_comb begin
    pend_nxt = pend_r;
    if (cmd.scan_start) pend_nxt = 1'b0;
    if (cfg_wr)         pend_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssle_pkg::S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ssle_pkg::S_FETCH)
    else $error("accepted word did not enter fetch");

  a_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ssle_pkg::S_REPORT |=> state_r == ssle_pkg::S_IDLE && !pend_r)
    else $error("report not followed by idle");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> busy)
    else $error("marker write did not hold off new words");
`endif

endmodule

// ===== src/ssle_dpath.sv =====
// ----------------------------------------------------------------------------
// ssle_dpath
// slot memory, occupancy and valid bits, occupied count, operation decode
// and result registers
// ----------------------------------------------------------------------------
module ssle_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssle_pkg::dp_cmd_t                   cmd,
  output ssle_pkg::dp_stat_t                  stat,
  input  logic [ssle_pkg::VAL_W-1:0]          marker,
  input  logic [ssle_pkg::OP_W-1:0]           in_operation,
  input  logic [ssle_pkg::IDX_W-1:0]          in_slot_index,
  input  logic [ssle_pkg::VAL_W-1:0]          in_element_value,
  output logic                                out_valid,
  output logic [ssle_pkg::VAL_W-1:0]          out_result_value,
  output logic [ssle_pkg::STS_W-1:0]          out_status,
  output logic [ssle_pkg::IDX_W-1:0]          out_first_index,
  output logic [ssle_pkg::IDX_W-1:0]          out_last_index,
  output logic [ssle_pkg::CNT_OUT_W-1:0]      out_occupied_count,
  output logic                                out_is_empty,
  output logic                                out_is_full,
  output logic                                out_index_effective
);

  localparam int N  = ssle_pkg::SLOT_COUNT;
  localparam int AW = ssle_pkg::ADDR_W;
  localparam int CW = ssle_pkg::CNT_W;
  localparam int VW = ssle_pkg::VAL_W;

  // latched word
  logic [ssle_pkg::OP_W-1:0]  op_r;
  logic [ssle_pkg::IDX_W-1:0] idx_r;
  logic [VW-1:0]              val_r;

  // slot state; a slot without its valid bit holds fill_r
  logic [N-1:0]  occ_r, occ_nxt;
  logic [N-1:0]  valid_r, valid_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [VW-1:0] fill_r, fill_nxt;

  // decoded operation
  logic [AW-1:0]  tgt_r, tgt_nxt;
  logic           wr_r, wr_nxt;
  logic [VW-1:0]  wval_r, wval_nxt;
  logic           rvsel_r, rvsel_nxt;
  logic           clr_r, clr_nxt;
  ssle_pkg::sts_t sts_r, sts_nxt;
  logic [VW-1:0]  rv_r;

  // sweep
  logic [AW-1:0] scan_cnt_r;
  logic [AW-1:0] scan_addr_r;
  logic          scan_rd_r;

  // ram
  logic [AW-1:0] ram_raddr;
  logic [VW-1:0] ram_rdata;
  logic          ram_we;

  // result registers
  logic                              out_valid_r;
  logic [VW-1:0]                     out_rv_r;
  ssle_pkg::sts_t                    out_sts_r;
  logic [ssle_pkg::IDX_W-1:0]        out_first_r, out_last_r;
  logic [ssle_pkg::CNT_OUT_W-1:0]    out_cnt_r;
  logic                              out_empty_r, out_full_r, out_eff_r;

  // helpers
  logic [AW-1:0]                    first, last;
  logic                             is_empty;
  logic [ssle_pkg::CMP_W-1:0]       idx_ext;
  logic                             idx_ok;
  logic [AW-1:0]                    idx_addr;
  logic [VW-1:0]                    rd_val;
  logic                             new_occ, old_occ, scan_occ;
  logic [ssle_pkg::CNT_CMP_W-1:0]   cnt_ext;

  assign first    = ssle_pkg::find_first(occ_r);
  assign last     = ssle_pkg::find_last(occ_r);
  assign is_empty = (count_r == '0);
  assign idx_ext  = ssle_pkg::CMP_W'(idx_r);
  assign idx_ok   = idx_ext < ssle_pkg::CMP_W'(N);
  assign idx_addr = AW'(idx_ext);

  ssle_ram #(
    .WIDTH (VW),
    .DEPTH (N)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tgt_r),
    .wdata (wval_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_we    = cmd.apply & wr_r;
  assign ram_raddr = cmd.scan_step ? scan_cnt_r : tgt_nxt;

  assign stat.scan_last = (scan_cnt_r == ssle_pkg::LAST_SLOT);

  // operation decode against current first/last
  always_comb begin
    tgt_nxt   = '0;
    wr_nxt    = 1'b0;
    wval_nxt  = val_r;
    rvsel_nxt = 1'b0;
    clr_nxt   = 1'b0;
    sts_nxt   = ssle_pkg::STS_OK;
    unique case (op_r)
      ssle_pkg::OP_CLEAR: clr_nxt = 1'b1;
      ssle_pkg::OP_INS_FIRST: begin
        priority if (is_empty) begin
          tgt_nxt = ssle_pkg::MID_SLOT;
          wr_nxt  = 1'b1;
        end else if (first == '0) begin
          sts_nxt = ssle_pkg::STS_NO_ROOM;
        end else begin
          tgt_nxt = first - AW'(1);
          wr_nxt  = 1'b1;
        end
      end
      ssle_pkg::OP_INS_LAST: begin
        priority if (is_empty) begin
          tgt_nxt = ssle_pkg::MID_SLOT;
          wr_nxt  = 1'b1;
        end else if (last == ssle_pkg::LAST_SLOT) begin
          sts_nxt = ssle_pkg::STS_NO_ROOM;
        end else begin
          tgt_nxt = last + AW'(1);
          wr_nxt  = 1'b1;
        end
      end
      ssle_pkg::OP_WRITE: begin
        tgt_nxt = idx_addr;
        wr_nxt  = idx_ok;
      end
      ssle_pkg::OP_DEL_FIRST, ssle_pkg::OP_DEL_LAST: begin
        if (is_empty) begin
          sts_nxt = ssle_pkg::STS_EMPTY;
        end else begin
          tgt_nxt   = (op_r == ssle_pkg::OP_DEL_FIRST) ? first : last;
          wr_nxt    = 1'b1;
          wval_nxt  = marker;
          rvsel_nxt = 1'b1;
        end
      end
      ssle_pkg::OP_DEL_AT: begin
        tgt_nxt   = idx_addr;
        wr_nxt    = idx_ok;
        wval_nxt  = marker;
        rvsel_nxt = idx_ok;
      end
      ssle_pkg::OP_READ: begin
        tgt_nxt   = idx_addr;
        rvsel_nxt = idx_ok;
      end
      default: ;
    endcase
  end

  assign rd_val   = valid_r[tgt_r] ? ram_rdata : fill_r;
  assign new_occ  = (wval_r != marker);
  assign old_occ  = occ_r[tgt_r];
  assign scan_occ = ((valid_r[scan_addr_r] ? ram_rdata : fill_r) != marker);

  // slot state update: apply step, clear, or one sweep entry
  always_comb begin
    occ_nxt   = occ_r;
    valid_nxt = valid_r;
    count_nxt = count_r;
    fill_nxt  = fill_r;
    if (cmd.apply && clr_r) begin
      occ_nxt   = '0;
      valid_nxt = '0;
      count_nxt = '0;
      fill_nxt  = marker;
    end else if (cmd.apply && wr_r) begin
      occ_nxt[tgt_r]   = new_occ;
      valid_nxt[tgt_r] = 1'b1;
      if (new_occ && !old_occ) count_nxt = count_r + CW'(1);
      if (!new_occ && old_occ) count_nxt = count_r - CW'(1);
    end
    if (cmd.scan_start) count_nxt = '0;
    if (scan_rd_r) begin
      occ_nxt[scan_addr_r] = scan_occ;
      if (scan_occ) count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      valid_r     <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      scan_rd_r   <= 1'b0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      scan_rd_r   <= cmd.scan_step;
      out_valid_r <= cmd.report;
      if (cmd.scan_start) begin
        scan_cnt_r <= '0;
      end else if (cmd.scan_step) begin
        scan_cnt_r <= scan_cnt_r + AW'(1);
      end
    end
  end

  assign cnt_ext = ssle_pkg::CNT_CMP_W'(count_r);

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      idx_r <= in_slot_index;
      val_r <= in_element_value;
    end
    if (cmd.fetch) begin
      tgt_r   <= tgt_nxt;
      wr_r    <= wr_nxt;
      wval_r  <= wval_nxt;
      rvsel_r <= rvsel_nxt;
      clr_r   <= clr_nxt;
      sts_r   <= sts_nxt;
    end
    if (cmd.apply) begin
      rv_r <= rvsel_r ? rd_val : '0;
    end
    scan_addr_r <= scan_cnt_r;
    if (cmd.report) begin
      out_rv_r    <= rv_r;
      out_sts_r   <= sts_r;
      out_first_r <= ssle_pkg::IDX_W'(ssle_pkg::CMP_W'(first));
      out_last_r  <= ssle_pkg::IDX_W'(ssle_pkg::CMP_W'(last));
      out_cnt_r   <= (cnt_ext > ssle_pkg::CNT_CMP_W'(ssle_pkg::CNT_SAT))
                     ? ssle_pkg::CNT_OUT_W'(ssle_pkg::CNT_SAT)
                     : ssle_pkg::CNT_OUT_W'(cnt_ext);
      out_empty_r <= is_empty;
      out_full_r  <= (count_r == CW'(N));
      // an occupied slot always lies between first and last
      out_eff_r   <= idx_ok & occ_r[idx_addr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_value    = out_rv_r;
  assign out_status          = out_sts_r;
  assign out_first_index     = out_first_r;
  assign out_last_index      = out_last_r;
  assign out_occupied_count  = out_cnt_r;
  assign out_is_empty        = out_empty_r;
  assign out_is_full         = out_full_r;
  assign out_index_effective = out_eff_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(N))
    else $error("occupied count beyond slot count");

  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_first_r == '0 && out_last_r == '0 &&
                                   out_cnt_r == '0 && !out_eff_r)
    else $error("empty result with occupancy data");

  a_apply_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply && wr_r |=> valid_r[$past(tgt_r)] &&
                          occ_r[$past(tgt_r)] == ($past(wval_r) != $past(marker)))
    else $error("slot write not reflected in occupancy");
`endif

endmodule

// ===== src/sparse_slot_list_engine.sv =====
// ----------------------------------------------------------------------------
// sparse_slot_list_engine
// fixed array of byte slots with a configurable empty marker, list operations
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; each word gives exactly
// one result, shown for one cycle with out_valid high after the fetch, apply
// and report states. The next word can be taken in the cycle its predecessor's
// result is shown, not earlier. The steps are decode against the occupancy
// encoders, slot memory read, write-back, then encode of the updated occupancy.
// The result side cannot stall and needs no ready. Every write of empty_marker
// rebuilds occupancy by sweeping the slot memory, one slot a cycle; busy stays
// high from the write until the sweep ends.
// ----------------------------------------------------------------------------
module sparse_slot_list_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [ssle_pkg::OP_W-1:0]           in_operation,
  input  logic [ssle_pkg::IDX_W-1:0]          in_slot_index,
  input  logic [ssle_pkg::VAL_W-1:0]          in_element_value,
  // result channel
  output logic                                out_valid,
  output logic [ssle_pkg::VAL_W-1:0]          out_result_value,
  output logic [ssle_pkg::STS_W-1:0]          out_status,
  output logic [ssle_pkg::IDX_W-1:0]          out_first_index,
  output logic [ssle_pkg::IDX_W-1:0]          out_last_index,
  output logic [ssle_pkg::CNT_OUT_W-1:0]      out_occupied_count,
  output logic                                out_is_empty,
  output logic                                out_is_full,
  output logic                                out_index_effective,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [ssle_pkg::VAL_W-1:0] marker_r;
  logic                       cfg_wr;
  ssle_pkg::dp_cmd_t          cmd;
  ssle_pkg::dp_stat_t         stat;

  assign pready = 1'b1;
  // only the empty marker register exists, decoded at offsets 0 to 3 (paddr[2] low)
  assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(marker_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= '0;
    end else if (cfg_wr) begin
      marker_r <= pwdata[ssle_pkg::VAL_W-1:0];
    end
  end

  ssle_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cfg_wr (cfg_wr),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  ssle_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .marker              (marker_r),
    .in_operation        (in_operation),
    .in_slot_index       (in_slot_index),
    .in_element_value    (in_element_value),
    .out_valid           (out_valid),
    .out_result_value    (out_result_value),
    .out_status          (out_status),
    .out_first_index     (out_first_index),
    .out_last_index      (out_last_index),
    .out_occupied_count  (out_occupied_count),
    .out_is_empty        (out_is_empty),
    .out_is_full         (out_is_full),
    .out_index_effective (out_index_effective)
  );

endmodule
